// ----- design/dfe_pkg.sv -----
// Shared types, constants and helpers for the DShot frame encoder.
package dfe_pkg;

    localparam int MOTORS_DEF = 4;
    localparam int MOTOR_W    = 2;
    localparam int THR_W      = 11;
    localparam int INTERVAL_W = 20;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAME_BITS = 16;
    localparam int BIT_W      = 4;
    localparam int PULSE_W    = 5;

    localparam logic [THR_W-1:0]   THR_MAX    = 11'd2047;
    localparam logic [PULSE_W-1:0] PULSE_ONE  = 5'd14;
    localparam logic [PULSE_W-1:0] PULSE_ZERO = 5'd7;

    // Input item kinds.
    localparam logic [1:0] KIND_THR = 2'd0;
    localparam logic [1:0] KIND_TEL = 2'd1;
    localparam logic [1:0] KIND_UPD = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_EN   = 2'd3;

    typedef enum logic [1:0] {
        OP_THR = 2'd0,
        OP_TEL = 2'd1,
        OP_UPD = 2'd2
    } t_op;

    typedef struct packed {
        logic [INTERVAL_W-1:0] update_interval_us;
        logic [COUNT_W-1:0]    motor_count;
        logic [3:0]            motor_enable_mask;
        logic                  outputs_enabled;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        logic [MOTOR_W-1:0] motor;
        logic [THR_W-1:0]   throttle;
    } t_cmd;

    // Throttle, telemetry bit, then the XOR of the three nibbles of that word.
    function automatic logic [FRAME_BITS-1:0] build_frame(input logic [THR_W-1:0] thr,
                                                          input logic tel);
        logic [11:0] word;
        logic [3:0]  sum;
        word = {thr, tel};
        sum  = word[3:0] ^ word[7:4] ^ word[11:8];
        return {word, sum};
    endfunction

endpackage

// ----- design/dfe_front.sv -----
// Front end: accepts items, filters them and turns the useful ones into commands.
module dfe_front import dfe_pkg::*; #(
    parameter int MOTORS = MOTORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_motor,
    input  logic [15:0] i_throttle,
    input  logic [31:0] i_now_us,
    input  logic        i_q_full,
    output logic        o_stall,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [31:0]        r_last_time;
    logic [31:0]        n_last_time;
    logic [COUNT_W-1:0] count_eff;
    logic [31:0]        elapsed;
    logic               accept;
    logic               thr_ok;
    logic               tel_ok;
    logic               upd_ok;
    logic               keep;

    assign o_stall   = i_q_full;
    assign accept    = i_valid && !i_q_full;
    assign count_eff = (i_cfg.motor_count > COUNT_W'(MOTORS)) ? COUNT_W'(MOTORS)
                                                              : i_cfg.motor_count;
    assign elapsed   = i_now_us - r_last_time;

    assign thr_ok = i_cfg.outputs_enabled && (i_motor < 8'(MOTORS));
    // Motor below the effective count implies motor < 4, so the low bits index the mask.
    assign tel_ok = ({5'd0, count_eff} > i_motor) &&
                    i_cfg.motor_enable_mask[i_motor[1:0]];
    assign upd_ok = (i_cfg.update_interval_us != '0) &&
                    (elapsed > {12'd0, i_cfg.update_interval_us});

    always_comb begin
        keep           = 1'b0;
        o_cmd.op       = OP_UPD;
        o_cmd.motor    = i_motor[MOTOR_W-1:0];
        o_cmd.throttle = (|i_throttle[15:THR_W]) ? THR_MAX : i_throttle[THR_W-1:0];
        n_last_time    = r_last_time;
        unique case (i_kind)
            KIND_THR: begin
                o_cmd.op = OP_THR;
                keep     = thr_ok;
            end
            KIND_TEL: begin
                o_cmd.op = OP_TEL;
                keep     = tel_ok;
            end
            KIND_UPD: begin
                o_cmd.op = OP_UPD;
                keep     = upd_ok;
                if (accept && upd_ok) begin
                    n_last_time = i_now_us;
                end
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = accept && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
        end else begin
            r_last_time <= n_last_time;
        end
    end

endmodule

// ----- design/dfe_queue.sv -----
// Two-entry command queue between the front end and the pulse sequencer.
module dfe_queue import dfe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = do_push ? !r_wp : r_wp;
        n_rp  = do_pop ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- design/dfe_back.sv -----
// Back end: holds motor state, applies commands and sequences frame pulses.
module dfe_back import dfe_pkg::*; #(
    parameter int MOTORS = MOTORS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_empty,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [MOTOR_W-1:0] o_motor_out,
    output logic [BIT_W-1:0]   o_bit_index,
    output logic [PULSE_W-1:0] o_pulse_width,
    output logic               o_last
);

    localparam int MIW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [MIW-1:0]     r_m;
    logic [MIW-1:0]     n_m;
    logic [BIT_W-1:0]   r_bit;
    logic [BIT_W-1:0]   n_bit;
    logic [THR_W-1:0]   r_thr [MOTORS];
    logic [MOTORS-1:0]  r_tel;

    logic               r_out_valid;
    logic [MOTOR_W-1:0] r_out_motor;
    logic [BIT_W-1:0]   r_out_bit;
    logic [PULSE_W-1:0] r_out_pw;
    logic               r_out_last;

    logic [COUNT_W-1:0]    count_eff;
    logic [MOTORS-1:0]     en;
    logic [MOTORS-1:0]     above;
    logic                  more;
    logic                  cur_en;
    logic                  out_free;
    logic                  emit;
    logic                  frame_end;
    logic [FRAME_BITS-1:0] frame;
    logic [MIW-1:0]        cmd_idx;

    assign count_eff = (i_cfg.motor_count > COUNT_W'(MOTORS)) ? COUNT_W'(MOTORS)
                                                              : i_cfg.motor_count;

    always_comb begin
        for (int i = 0; i < MOTORS; i++) begin
            en[i]    = i_cfg.motor_enable_mask[i] && (COUNT_W'(i) < count_eff);
            above[i] = (MIW'(i) > r_m);
        end
    end

    assign more      = |(en & above);
    assign cur_en    = en[r_m];
    assign out_free  = !r_out_valid || !i_stall;
    assign frame     = build_frame(r_thr[r_m], r_tel[r_m]);
    assign emit      = (r_state == ST_RUN) && cur_en && out_free;
    assign frame_end = emit && (r_bit == BIT_W'(FRAME_BITS - 1));
    assign o_pop     = (r_state == ST_IDLE) && !i_q_empty;
    assign cmd_idx   = i_cmd.motor[MIW-1:0];

    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_bit   = r_bit;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop && i_cmd.op == OP_UPD && (|en)) begin
                    n_state = ST_RUN;
                    n_m     = '0;
                    n_bit   = '0;
                end
            end
            ST_RUN: begin
                if (!cur_en) begin
                    n_m = r_m + MIW'(1);
                end else if (emit) begin
                    n_bit = r_bit + BIT_W'(1);
                    if (frame_end) begin
                        if (more) begin
                            n_m = r_m + MIW'(1);
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_motor <= MOTOR_W'(r_m);
            r_out_bit   <= r_bit;
            // Bit 15 - b is the same as the inverted 4-bit index.
            r_out_pw    <= frame[~r_bit] ? PULSE_ONE : PULSE_ZERO;
            r_out_last  <= frame_end && !more;
        end
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_m         <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
            r_tel       <= '0;
            for (int i = 0; i < MOTORS; i++) begin
                r_thr[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_m     <= n_m;
            r_bit   <= n_bit;
            if (out_free) begin
                r_out_valid <= emit;
            end
            if (o_pop && i_cmd.op == OP_THR) begin
                r_thr[cmd_idx] <= i_cmd.throttle;
            end
            if (o_pop && i_cmd.op == OP_TEL) begin
                r_tel[cmd_idx] <= 1'b1;
            end
            if (frame_end) begin
                r_tel[r_m] <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_motor_out   = r_out_motor;
    assign o_bit_index   = r_out_bit;
    assign o_pulse_width = r_out_pw;
    assign o_last        = r_out_last;

endmodule

// ----- design/dshot_frame_encoder.sv -----
// An item is written into the queue at the edge that accepts it and is popped once the back
// end is idle, where throttle and telemetry writes apply; a firing update then starts the
// sequencer, whose pulses leave through an output register. Throughput: one item per cycle
// while the two-entry queue has room. A firing update walks every enabled motor and each
// disabled motor below the last enabled one, one pulse per cycle unless the receiver stalls.
// Reset: synchronous, active low; clears throttles, telemetry flags, the last update time,
// the queue and the output register, and loads the default configuration.
module dshot_frame_encoder import dfe_pkg::*; #(
    parameter int MOTORS = MOTORS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [INTERVAL_W-1:0] i_cfg_data,
    // Input item channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_motor,
    input  logic [15:0]           i_throttle,
    input  logic [31:0]           i_now_us,
    // Pulse item channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [MOTOR_W-1:0]    o_motor_out,
    output logic [BIT_W-1:0]      o_bit_index,
    output logic [PULSE_W-1:0]    o_pulse_width,
    output logic                  o_last
);

    // Configuration registers. The user must change them only while the block is idle;
    // the block itself does not enforce this, and both halves read them directly.
    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INTERVAL: n_cfg.update_interval_us = i_cfg_data;
                CFG_COUNT:    n_cfg.motor_count        = i_cfg_data[COUNT_W-1:0];
                CFG_MASK:     n_cfg.motor_enable_mask  = i_cfg_data[3:0];
                CFG_OUT_EN:   n_cfg.outputs_enabled    = i_cfg_data[0];
                default:      n_cfg                    = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.update_interval_us <= '0;
            r_cfg.motor_count        <= COUNT_W'(4);
            r_cfg.motor_enable_mask  <= 4'hf;
            r_cfg.outputs_enabled    <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // The front end filters items and owns the last update time, so the interval
    // check is settled at acceptance. Surviving items become queued commands.
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    dfe_front #(.MOTORS(MOTORS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .i_kind     (i_kind),
        .i_motor    (i_motor),
        .i_throttle (i_throttle),
        .i_now_us   (i_now_us),
        .i_q_full   (q_full),
        .o_stall    (o_stall),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    dfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    // The back end executes commands in order: throttle and telemetry updates apply when
    // popped, a frame update walks the enabled motors and sends sixteen pulses each.
    // Because commands are strictly ordered, a later throttle write never leaks
    // into a frame that an earlier update started.
    dfe_back #(.MOTORS(MOTORS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_empty     (q_empty),
        .i_cmd         (head_cmd),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_motor_out   (o_motor_out),
        .o_bit_index   (o_bit_index),
        .o_pulse_width (o_pulse_width),
        .o_last        (o_last)
    );

    // The final pulse of an update always closes a frame.
    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_bit_index == BIT_W'(FRAME_BITS - 1))
        else $error("last pulse does not close a frame");

    // Within a frame, the next pulse follows right after one is taken.
    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last && o_bit_index != BIT_W'(FRAME_BITS - 1)
        |=> o_valid && o_bit_index == $past(o_bit_index) + BIT_W'(1) &&
            o_motor_out == $past(o_motor_out))
        else $error("frame pulses not contiguous");

    // Out of reset no pulse is pending.
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("pulse valid right after reset");

endmodule

// ----- bench/dshot_pulse_checker.sv -----
`timescale 1ns / 1ps
// Pulse checker for the DShot frame encoder: mirrors the block's state and compares pulse items.
module dshot_pulse_checker import dfe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [INTERVAL_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_motor,
    input  logic [15:0]           i_throttle,
    input  logic [31:0]           i_now_us,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [MOTOR_W-1:0]    i_motor_out,
    input  logic [BIT_W-1:0]      i_bit_index,
    input  logic [PULSE_W-1:0]    i_pulse_width,
    input  logic                  i_last,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [MOTOR_W-1:0] motor;
        logic [BIT_W-1:0]   bit_pos;
        logic [PULSE_W-1:0] width;
        logic               last;
    } pulse_t;

    t_cfg                  cfg;
    logic [THR_W-1:0]      thr_mirror [MOTORS_DEF];
    logic [MOTORS_DEF-1:0] tel_mirror;
    logic [31:0]           stamp_mirror;
    pulse_t                pulse_q [$];

    // Throttle and telemetry bit, closed by the XOR of the word's three nibbles.
    function automatic logic [15:0] dshot_word(input logic [THR_W-1:0] thr, input logic tel);
        logic [11:0] payload;
        logic [3:0]  csum;
        payload = {thr, tel};
        csum = 4'h0;
        for (int n = 0; n < 3; n++) begin
            csum = csum ^ payload[n*4 +: 4];
        end
        return {payload, csum};
    endfunction

    function automatic void flag_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        o_errors++;
    endfunction

    task automatic expand_item(input logic [1:0] kind, input logic [7:0] motor,
                               input logic [15:0] thr, input logic [31:0] now);
        int          served;
        int          last_motor;
        logic [31:0] gap;
        logic [15:0] frame;
        pulse_t      p;
        served = (cfg.motor_count > MOTORS_DEF) ? MOTORS_DEF : int'(cfg.motor_count);
        case (kind)
            KIND_THR: begin
                if (cfg.outputs_enabled && motor < MOTORS_DEF) begin
                    thr_mirror[motor[MOTOR_W-1:0]] = (thr > THR_MAX) ? THR_MAX : thr[THR_W-1:0];
                end
            end
            KIND_TEL: begin
                if (motor < served && cfg.motor_enable_mask[motor[MOTOR_W-1:0]]) begin
                    tel_mirror[motor[MOTOR_W-1:0]] = 1'b1;
                end
            end
            KIND_UPD: begin
                gap = now - stamp_mirror;
                if (cfg.update_interval_us != '0 && gap > 32'(cfg.update_interval_us)) begin
                    stamp_mirror = now;
                    last_motor = -1;
                    for (int m = 0; m < served; m++) begin
                        if (cfg.motor_enable_mask[m]) last_motor = m;
                    end
                    for (int m = 0; m < served; m++) begin
                        if (cfg.motor_enable_mask[m]) begin
                            frame = dshot_word(thr_mirror[m], tel_mirror[m]);
                            for (int b = 0; b < FRAME_BITS; b++) begin
                                p.motor   = MOTOR_W'(m);
                                p.bit_pos = BIT_W'(b);
                                p.width   = frame[FRAME_BITS-1-b] ? PULSE_ONE : PULSE_ZERO;
                                p.last    = (m == last_motor) && (b == FRAME_BITS - 1);
                                pulse_q.push_back(p);
                            end
                            tel_mirror[m] = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        pulse_t want;
        if (!i_rst_n) begin
            cfg.update_interval_us = '0;
            cfg.motor_count        = 3'd4;
            cfg.motor_enable_mask  = 4'hf;
            cfg.outputs_enabled    = 1'b1;
            for (int m = 0; m < MOTORS_DEF; m++) thr_mirror[m] = '0;
            tel_mirror   = '0;
            stamp_mirror = '0;
            pulse_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INTERVAL: cfg.update_interval_us = i_cfg_data;
                    CFG_COUNT:    cfg.motor_count        = i_cfg_data[COUNT_W-1:0];
                    CFG_MASK:     cfg.motor_enable_mask  = i_cfg_data[3:0];
                    CFG_OUT_EN:   cfg.outputs_enabled    = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expand_item(i_kind, i_motor, i_throttle, i_now_us);
            end
            if (i_out_valid && !i_out_stall) begin
                if (pulse_q.size() == 0) begin
                    $display({"%0t: unexpected pulse, expected none, ",
                              "actual motor %0d bit %0d width %0d last %0d"},
                             $time, i_motor_out, i_bit_index, i_pulse_width, i_last);
                    o_errors++;
                end else begin
                    want = pulse_q.pop_front();
                    if (i_motor_out !== want.motor) begin
                        flag_field("motor_out", 32'(want.motor), 32'(i_motor_out));
                    end
                    if (i_bit_index !== want.bit_pos) begin
                        flag_field("bit_index", 32'(want.bit_pos), 32'(i_bit_index));
                    end
                    if (i_pulse_width !== want.width) begin
                        flag_field("pulse_width", 32'(want.width), 32'(i_pulse_width));
                    end
                    if (i_last !== want.last) begin
                        flag_field("last", 32'(want.last), 32'(i_last));
                    end
                end
            end
        end
        o_pending <= pulse_q.size();
    end

endmodule

// ----- bench/dshot_frame_encoder_tb.sv -----
`timescale 1ns / 1ps
// Top-level bench for the DShot frame encoder: clock, reset, register setup, item traffic, verdict.
module dshot_frame_encoder_tb;
    import dfe_pkg::*;

    // Cycles with no item moving on either channel before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Pause after the last expected pulse so queued throttle writes can drain.
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 18;
    // The block ignores this kind entirely.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [INTERVAL_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            kind;
    logic [7:0]            motor;
    logic [15:0]           throttle;
    logic [31:0]           now_us;
    logic                  pulse_valid;
    logic                  pulse_stall = 1'b0;
    logic [MOTOR_W-1:0]    pulse_motor;
    logic [BIT_W-1:0]      pulse_bit;
    logic [PULSE_W-1:0]    pulse_width;
    logic                  pulse_last;

    int                    fails;
    int                    pending;
    int                    quiet;
    int                    tx_idle_pct;
    int                    rx_stall_pct;
    // Running time base for update items and the interval currently programmed.
    logic [31:0]           tick_time;
    logic [INTERVAL_W-1:0] cur_interval;

    dshot_frame_encoder i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_kind        (kind),
        .i_motor       (motor),
        .i_throttle    (throttle),
        .i_now_us      (now_us),
        .o_valid       (pulse_valid),
        .i_stall       (pulse_stall),
        .o_motor_out   (pulse_motor),
        .o_bit_index   (pulse_bit),
        .o_pulse_width (pulse_width),
        .o_last        (pulse_last)
    );

    dshot_pulse_checker pulse_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_kind        (kind),
        .i_motor       (motor),
        .i_throttle    (throttle),
        .i_now_us      (now_us),
        .i_out_valid   (pulse_valid),
        .i_out_stall   (pulse_stall),
        .i_motor_out   (pulse_motor),
        .i_bit_index   (pulse_bit),
        .i_pulse_width (pulse_width),
        .i_last        (pulse_last),
        .o_errors      (fails),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random; the rate is set per phase.
    always @(posedge clk) begin
        pulse_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // Watchdog: the run is hung if neither channel moves an item for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (pulse_valid && !pulse_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("dshot_frame_encoder verification failed");
            $finish;
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            IDLE_SENDER:   begin tx_idle_pct = 83; rx_stall_pct = 0;  end
            IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
            default:       begin tx_idle_pct = 29; rx_stall_pct = 29; end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [INTERVAL_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Registers change only while the block is idle. Once the last expected pulse is out,
    // a short pause lets throttle writes still sitting in the block's queue take effect.
    // The narrow registers get random upper data bits, which the block must ignore.
    task automatic program_block(input logic [INTERVAL_W-1:0] interval,
                                 input logic [COUNT_W-1:0] count,
                                 input logic [3:0] mask, input logic en);
        logic [INTERVAL_W-1:0] junk;
        junk = INTERVAL_W'($urandom);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_INTERVAL, interval);
        write_reg(CFG_COUNT, {junk[INTERVAL_W-1:COUNT_W], count});
        write_reg(CFG_MASK, {junk[INTERVAL_W-1:4], mask});
        write_reg(CFG_OUT_EN, {junk[INTERVAL_W-1:1], en});
        cfg_we <= 1'b0;
        cur_interval = interval;
    endtask

    // Presents one item, possibly after a random idle gap, and returns at the clock edge
    // that accepts it. Valid stays high into the next item when there is no gap.
    task automatic send_item(input logic [1:0] k, input logic [7:0] m, input logic [15:0] t,
                             input logic [31:0] n);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        motor    <= m;
        throttle <= t;
        now_us   <= n;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Mostly meaningful traffic: writes to real motors, telemetry requests and updates
    // that arrive after the interval. The rest are early updates, time jumps, stray motor
    // indexes and the unused kind. Fields a kind does not use carry noise.
    task automatic random_item(output bit useful);
        int          pick;
        int          sel;
        logic [1:0]  k;
        logic [7:0]  m;
        logic [15:0] t;
        logic [31:0] n;
        pick = $urandom_range(99);
        m = ($urandom_range(99) < 85) ? 8'($urandom_range(0, MOTORS_DEF - 1)) : 8'($urandom);
        t = 16'($urandom);
        n = $urandom;
        if (pick < 35) begin
            k = KIND_THR;
            case ($urandom_range(3))
                0: t = 16'($urandom_range(0, 2047));
                1: t = 16'($urandom);
                default: begin
                    case ($urandom_range(3))
                        0:       t = 16'd0;
                        1:       t = 16'd2047;
                        2:       t = 16'd2048;
                        default: t = 16'hffff;
                    endcase
                end
            endcase
        end else if (pick < 52) begin
            k = KIND_TEL;
        end else if (pick < 93) begin
            k = KIND_UPD;
            sel = $urandom_range(99);
            if (sel < 72) begin
                tick_time = tick_time + 32'(cur_interval) + 32'd1 + 32'($urandom_range(0, 64));
            end else if (sel < 88) begin
                tick_time = tick_time + 32'($urandom_range(0, cur_interval));
            end else begin
                tick_time = $urandom;
            end
            n = tick_time;
        end else begin
            k = KIND_UNUSED;
            m = 8'($urandom);
        end
        useful = (k != KIND_UNUSED);
        send_item(k, m, t, n);
    endtask

    initial begin
        int done;
        bit useful;
        logic [INTERVAL_W-1:0] ivl;
        logic [COUNT_W-1:0]    cnt;
        logic [3:0]            msk;
        logic                  en;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        kind      <= '0;
        motor     <= '0;
        throttle  <= '0;
        now_us    <= '0;
        tick_time = '0;
        cur_interval = '0;
        set_idling(IDLE_NONE);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Default registers: interval zero, so no update may emit anything.
        send_item(KIND_THR, 8'd0, 16'd0, 32'd0);
        send_item(KIND_THR, 8'd1, 16'd2047, 32'd0);
        send_item(KIND_THR, 8'd2, 16'hffff, 32'hffff_ffff);   // clamped
        send_item(KIND_THR, 8'd3, 16'd2048, 32'd0);           // clamped
        send_item(KIND_THR, 8'd4, 16'd1234, 32'd0);           // motor out of range
        send_item(KIND_THR, 8'd255, 16'd7, 32'd0);            // motor out of range
        send_item(KIND_TEL, 8'd1, 16'd0, 32'd0);
        send_item(KIND_TEL, 8'd200, 16'd0, 32'd0);            // ignored
        send_item(KIND_UNUSED, 8'hff, 16'hffff, 32'hffff_ffff);
        send_item(KIND_UPD, 8'd0, 16'd0, 32'd5000);           // output disabled by interval

        program_block(20'd100, 3'd4, 4'hf, 1'b1);
        send_item(KIND_UPD, 8'd0, 16'd0, 32'd50);             // too early
        send_item(KIND_UPD, 8'd0, 16'd0, 32'd100);            // exactly the interval: still early
        send_item(KIND_UPD, 8'd0, 16'd0, 32'd101);            // all four motors, telemetry on 1
        send_item(KIND_TEL, 8'd3, 16'd0, 32'd0);
        send_item(KIND_UPD, 8'd0, 16'd0, 32'hffff_fff0);
        send_item(KIND_UPD, 8'd0, 16'd0, 32'h0000_0040);      // wrapped, too early
        send_item(KIND_UPD, 8'd0, 16'd0, 32'h0000_0060);      // wrapped, fires
        send_item(KIND_THR, 8'd2, 16'd1, 32'd0);

        // Count above the motor number saturates; motors 1 and 2 are masked off and
        // throttle writes are refused.
        program_block(20'd1, 3'd7, 4'b1001, 1'b0);
        send_item(KIND_THR, 8'd0, 16'd500, 32'd0);
        send_item(KIND_TEL, 8'd1, 16'd0, 32'd0);
        send_item(KIND_TEL, 8'd3, 16'd0, 32'd0);
        send_item(KIND_UPD, 8'd0, 16'd0, 32'h0000_0062);

        // No motor served: telemetry refused, the update only stores its time.
        program_block(20'hfffff, 3'd0, 4'hf, 1'b1);
        send_item(KIND_TEL, 8'd0, 16'd0, 32'd0);
        send_item(KIND_UPD, 8'd0, 16'd0, 32'h0020_0000);
        tick_time = 32'h0020_0000;

        // Random phases, each with its own register setting and idling pattern.
        for (int ph = 0; ph < PHASES; ph++) begin
            ivl = 20'($urandom_range(2, 5000));
            cnt = 3'($urandom_range(1, 4));
            msk = 4'($urandom_range(1, 15));
            en  = 1'b1;
            case (ph)
                0: begin ivl = 20'd1; cnt = 3'd4; msk = 4'hf; end
                1: begin ivl = 20'd1000000; cnt = 3'd7; msk = 4'b1010; end
                2: begin ivl = 20'hfffff; cnt = 3'd3; en = 1'b0; end
                3: begin cnt = 3'd0; msk = 4'hf; end
                4: cnt = 3'd2;
                5: cnt = 3'd5;
                6: begin msk = 4'hf; en = 1'b0; end
                default: begin ivl = 20'd0; msk = 4'h0; end
            endcase
            program_block(ivl, cnt, msk, en);
            set_idling(idle_mode_t'(ph % 4));
            done = 0;
            while (done < ITEMS_PER_PHASE) begin
                random_item(useful);
                if (useful) done++;
            end
        end

        // Drain: wait for every expected pulse, then a little longer for strays.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fails == 0 && pending == 0) begin
            $display("dshot_frame_encoder verification clean");
        end else begin
            $display("dshot_frame_encoder verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/dfe_pkg.sv
design/dfe_front.sv
design/dfe_queue.sv
design/dfe_back.sv
design/dshot_frame_encoder.sv
bench/dshot_pulse_checker.sv
bench/dshot_frame_encoder_tb.sv
